// ----- rtl/core/mhed_pkg.sv -----
// ----------------------------------------------------------------------------
// mhed_pkg
// Shared types and constants for the Marr-Hildreth edge detector.
// ----------------------------------------------------------------------------
package mhed_pkg;

   localparam int SIZE_W      = 13;
   localparam int MIN_SIZE    = 9;
   localparam int RAW_ROWS    = 6;
   localparam int SMOOTH_W    = 19;
   localparam int RING_W      = 22;
   localparam int LAP_W       = 24;
   localparam int BUCKET_W    = 11;
   localparam int GAUSS_TAPS  = 19;
   localparam int WIN         = 7;
   localparam int QUEUE_DEPTH = 4;
   localparam int RES_START   = 8;
   localparam int OFFSET      = 4;
   localparam int CSR_W       = 14;

   // Q8 weight by squared distance from the window centre
   localparam logic [8:0] GAUSS_Q8 [GAUSS_TAPS] = '{
      9'd256, 9'd155, 9'd94, 9'd0, 9'd35, 9'd21, 9'd0, 9'd0, 9'd5, 9'd3,
      9'd2, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0
   };

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_THRESH = 2'd2
   } csr_index_type;

   typedef logic [SIZE_W-1:0] size_type;

   typedef struct packed {
      logic [7:0] pixel;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic       edge_res;
      logic [9:0] out_row;
      logic [9:0] out_col;
      logic       frame_last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] pixel;
      logic       res;
      logic [9:0] out_row;
      logic [9:0] out_col;
      logic       last;
   } task_type;

endpackage

// ----- rtl/core/marr_hildreth_edge_detector.sv -----
// ----------------------------------------------------------------------------
// marr_hildreth_edge_detector
// 7x7 Gaussian smoothing, 3x3 Laplacian and threshold over a raster stream.
// ----------------------------------------------------------------------------
// Takes one pixel request per clock while the output is not stalled; a result
// for a pixel passes the queue and then the seven pipeline stages through the
// raw line store, the Gaussian sum, the smoothed line store and the Laplacian.
// Each line store is one memory, read and written once per pixel, so one pixel
// per clock is the ceiling. Only interior positions produce a response. No
// clearing pass follows reset.
module marr_hildreth_edge_detector #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  mhed_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output mhed_pkg::rsp_type  rsp_data,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [13:0]        csr_data
);
   import mhed_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int DW = $bits(task_type) + CW;

   logic [10:0]   width_ff, height_ff;
   logic [13:0]   thresh_ff;
   logic          q_full, q_push, q_pop, q_vld;
   task_type      f_task, h_task;
   logic [CW-1:0] f_col, h_col;
   logic [DW-1:0] q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd640;
         height_ff <= 11'd480;
         thresh_ff <= 14'd128;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_data[10:0];
            CSR_HEIGHT: height_ff <= csr_data[10:0];
            CSR_THRESH: thresh_ff <= csr_data;
            default: ;
         endcase
      end
   end

   mhed_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .image_width  (width_ff),
      .image_height (height_ff),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_task       (f_task),
      .q_col        (f_col)
   );

   mhed_queue #(.DW(DW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({f_task, f_col}),
      .pop       (q_pop),
      .head_data (q_head),
      .not_empty (q_vld),
      .full      (q_full)
   );

   assign h_task = q_head[DW-1:CW];
   assign h_col  = q_head[CW-1:0];

   mhed_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_vld       (q_vld),
      .head_task      (h_task),
      .head_col       (h_col),
      .pop            (q_pop),
      .edge_threshold (thresh_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data)
   );

endmodule

// ----- rtl/core/mhed_front.sv -----
// ----------------------------------------------------------------------------
// mhed_front
// Takes pixel requests, tracks the raster position and tags each request.
// ----------------------------------------------------------------------------
module mhed_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  mhed_pkg::req_type                 req_data,
   input  logic [10:0]                       image_width,
   input  logic [10:0]                       image_height,
   input  logic                              q_full,
   output logic                              q_push,
   output mhed_pkg::task_type                q_task,
   output logic [$clog2(MAX_WIDTH)-1:0]      q_col
);
   import mhed_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   logic [CW-1:0] col_ff, col_in, col_cur;
   logic [RW-1:0] row_ff, row_in, row_cur;
   size_type      w_eff, h_eff, col_nx, row_nx;
   logic [CW-1:0] col_m4;
   logic [RW-1:0] row_m4;

   always_comb begin
      if (SIZE_W'(image_width) < SIZE_W'(MIN_SIZE)) w_eff = SIZE_W'(MIN_SIZE);
      else if (SIZE_W'(image_width) > SIZE_W'(MAX_WIDTH)) w_eff = SIZE_W'(MAX_WIDTH);
      else w_eff = SIZE_W'(image_width);
      if (SIZE_W'(image_height) < SIZE_W'(MIN_SIZE)) h_eff = SIZE_W'(MIN_SIZE);
      else if (SIZE_W'(image_height) > SIZE_W'(MAX_HEIGHT)) h_eff = SIZE_W'(MAX_HEIGHT);
      else h_eff = SIZE_W'(image_height);
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign col_cur   = req_data.frame_start ? '0 : col_ff;
   assign row_cur   = req_data.frame_start ? '0 : row_ff;
   assign col_nx    = SIZE_W'(col_cur) + SIZE_W'(1);
   assign row_nx    = SIZE_W'(row_cur) + SIZE_W'(1);
   assign col_m4    = col_cur - CW'(OFFSET);
   assign row_m4    = row_cur - RW'(OFFSET);

   always_comb begin
      q_task.pixel   = req_data.pixel;
      q_task.res     = (SIZE_W'(row_cur) >= SIZE_W'(RES_START))
                       && (SIZE_W'(col_cur) >= SIZE_W'(RES_START));
      q_task.out_row = 10'(row_m4);
      q_task.out_col = 10'(col_m4);
      q_task.last    = (row_nx >= h_eff) && (col_nx >= w_eff);
      q_col          = col_cur;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (q_push) begin
         if (col_nx >= w_eff) begin
            col_in = '0;
            row_in = (row_nx >= h_eff) ? '0 : RW'(row_nx);
         end else begin
            col_in = CW'(col_nx);
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// ----- rtl/core/mhed_queue.sv -----
// ----------------------------------------------------------------------------
// mhed_queue
// Short request queue between the front and the filter pipeline.
// ----------------------------------------------------------------------------
module mhed_queue #(
   parameter int DW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  logic [DW-1:0] push_data,
   input  logic          pop,
   output logic [DW-1:0] head_data,
   output logic          not_empty,
   output logic          full
);
   import mhed_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   logic [DW-1:0] slot_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [NW-1:0] count_ff, count_in;
   logic          do_pop;

   assign not_empty = count_ff != '0;
   assign full      = count_ff == NW'(QUEUE_DEPTH);
   assign head_data = slot_ff[rd_ff];
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) wr_in = (wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      if (do_pop) rd_in = (rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      if (push && !do_pop) count_in = count_ff + NW'(1);
      else if (do_pop && !push) count_in = count_ff - NW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_data;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NW'(QUEUE_DEPTH)) else $error("queue count beyond depth");
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      do_pop && !push |=> count_ff == $past(count_ff) - NW'(1))
      else $error("queue count not reduced on pop");

endmodule

// ----- rtl/core/mhed_back.sv -----
// ----------------------------------------------------------------------------
// mhed_back
// Line stores, 7x7 Gaussian, 3x3 Laplacian, threshold and result register.
// ----------------------------------------------------------------------------
module mhed_back #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_vld,
   input  mhed_pkg::task_type            head_task,
   input  logic [$clog2(MAX_WIDTH)-1:0]  head_col,
   output logic                          pop,
   input  logic [13:0]                   edge_threshold,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output mhed_pkg::rsp_type             rsp_data
);
   import mhed_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int NS = 7;
   localparam int RAW_BITS = RAW_ROWS * 8;

   logic                    adv;
   logic                    vld_ff  [NS];
   task_type                task_ff [NS];
   logic [CW-1:0]           col_ff  [NS];

   logic [RAW_BITS-1:0]     raw_mem [MAX_WIDTH];
   logic [RAW_BITS-1:0]     raw_rd_ff, raw_wr;
   logic [2*SMOOTH_W-1:0]   sm_mem  [MAX_WIDTH];
   logic [2*SMOOTH_W-1:0]   sm_rd_ff, sm_wr;

   logic [7:0]              raw_win_ff [WIN][WIN];
   logic [7:0]              col7 [WIN];
   logic [BUCKET_W-1:0]     bucket [GAUSS_TAPS];
   logic [BUCKET_W-1:0]     bucket_ff [GAUSS_TAPS];
   logic [SMOOTH_W-1:0]     smooth_sum, smooth_ff, smooth_b6_ff;
   logic [SMOOTH_W-1:0]     sm_win_ff [3][3];
   logic [SMOOTH_W-1:0]     col3 [3];
   logic [RING_W-1:0]       ring, ring_ff, cen_ff;
   logic signed [LAP_W-1:0] lap, thr_q8;

   logic                    rsp_valid_ff;
   rsp_type                 rsp_data_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign pop       = adv && head_vld;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // stage 0 holds the item whose raw column is in raw_rd_ff
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= head_vld;
         for (int i = 1; i < NS; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         task_ff[0] <= head_task;
         col_ff[0]  <= head_col;
         for (int i = 1; i < NS; i++) begin
            task_ff[i] <= task_ff[i-1];
            col_ff[i]  <= col_ff[i-1];
         end
      end
   end

   // raw line store, newest row in the low byte
   assign raw_wr = {raw_rd_ff[RAW_BITS-9:0], task_ff[0].pixel};

   always_ff @(posedge clock) begin
      if (adv) begin
         if (vld_ff[0]) raw_mem[col_ff[0]] <= raw_wr;
         if (vld_ff[0] && col_ff[0] == head_col) raw_rd_ff <= raw_wr;
         else raw_rd_ff <= raw_mem[head_col];
      end
   end

   always_comb begin
      for (int y = 0; y < RAW_ROWS; y++) col7[y] = raw_rd_ff[(RAW_ROWS-1-y)*8 +: 8];
      col7[WIN-1] = task_ff[0].pixel;
   end

   always_ff @(posedge clock) begin
      if (adv && vld_ff[0]) begin
         for (int y = 0; y < WIN; y++) begin
            for (int x = 0; x < WIN-1; x++) raw_win_ff[y][x] <= raw_win_ff[y][x+1];
            raw_win_ff[y][WIN-1] <= col7[y];
         end
      end
   end

   // Gaussian: pixels grouped by squared distance, then weighted
   always_comb begin
      for (int d = 0; d < GAUSS_TAPS; d++) bucket[d] = '0;
      for (int y = 0; y < WIN; y++)
         for (int x = 0; x < WIN; x++)
            bucket[(y-3)*(y-3)+(x-3)*(x-3)] += BUCKET_W'(raw_win_ff[y][x]);
   end

   always_comb begin
      smooth_sum = '0;
      for (int d = 0; d < GAUSS_TAPS; d++)
         smooth_sum += SMOOTH_W'(bucket_ff[d]) * SMOOTH_W'(GAUSS_Q8[d]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int d = 0; d < GAUSS_TAPS; d++) bucket_ff[d] <= bucket[d];
         smooth_ff <= smooth_sum;
      end
   end

   // smoothed line store, newest row in the low half
   assign sm_wr = {sm_rd_ff[SMOOTH_W-1:0], smooth_b6_ff};

   always_ff @(posedge clock) begin
      if (adv) begin
         smooth_b6_ff <= smooth_ff;
         if (vld_ff[4]) sm_mem[col_ff[4]] <= sm_wr;
         if (vld_ff[4] && col_ff[4] == col_ff[3]) sm_rd_ff <= sm_wr;
         else sm_rd_ff <= sm_mem[col_ff[3]];
      end
   end

   always_comb begin
      col3[0] = sm_rd_ff[2*SMOOTH_W-1:SMOOTH_W];
      col3[1] = sm_rd_ff[SMOOTH_W-1:0];
      col3[2] = smooth_b6_ff;
   end

   always_ff @(posedge clock) begin
      if (adv && vld_ff[4]) begin
         for (int y = 0; y < 3; y++) begin
            sm_win_ff[y][0] <= sm_win_ff[y][1];
            sm_win_ff[y][1] <= sm_win_ff[y][2];
            sm_win_ff[y][2] <= col3[y];
         end
      end
   end

   // Laplacian: ring of eight minus eight times the centre
   always_comb begin
      ring = '0;
      for (int y = 0; y < 3; y++)
         for (int x = 0; x < 3; x++)
            if (y != 1 || x != 1) ring += RING_W'(sm_win_ff[y][x]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ring_ff <= ring;
         cen_ff  <= {sm_win_ff[1][1], 3'b000};
      end
   end

   assign lap    = $signed(LAP_W'(ring_ff)) - $signed(LAP_W'(cen_ff));
   assign thr_q8 = $signed(LAP_W'({edge_threshold, 8'h00}));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[NS-1] && task_ff[NS-1].res;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff.edge_res   <= lap > thr_q8;
         rsp_data_ff.out_row    <= task_ff[NS-1].out_row;
         rsp_data_ff.out_col    <= task_ff[NS-1].out_col;
         rsp_data_ff.frame_last <= task_ff[NS-1].last;
      end
   end

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !adv |=> vld_ff[0] == $past(vld_ff[0]) && vld_ff[NS-1] == $past(vld_ff[NS-1]))
      else $error("pipeline moved while output stalled");
   a_interior_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.out_row >= 10'd4 && rsp_data_ff.out_col >= 10'd4)
      else $error("result given for a border position");

endmodule
